### design/lclp_pkg.sv
// ----------------------------------------------------------------------------
// lclp_pkg: shared types and constants of the LED command-line parser
// Character codes, prefix text, limits, register indexes and the result type.
// ----------------------------------------------------------------------------
`default_nettype none

package lclp_pkg;

	localparam int MAX_LINE   = 15;
	localparam int MAX_DIGITS = 4;

	localparam int POS_W  = 5;
	localparam int CNT_W  = 3;
	localparam int LED_W  = 4;
	localparam int TIME_W = 14;
	localparam int CFG_W  = 14;
	localparam int ACCX_W = 18;

	localparam logic [POS_W-1:0]  POS_MAX = 5'd31;
	localparam logic [TIME_W-1:0] ACC_MAX = 14'd16383;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [LED_W-1:0]  LED_TOP_MAX    = 4'd9;
	localparam logic [LED_W-1:0]  DEF_LED_COUNT  = 4'd4;
	localparam logic [TIME_W-1:0] DEF_TIME_LIMIT = 14'd5000;

	localparam int SETLED_LEN = 8;
	localparam int ECHO_LEN   = 5;
	localparam int POS_LED    = 8;
	localparam int POS_COMMA  = 9;
	localparam int POS_DIGITS = 10;

	typedef enum logic [0:0] {
		REG_LED_COUNT  = 1'b0,
		REG_TIME_LIMIT = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SETLED = 2'd1,
		KIND_ECHO   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [TIME_W-1:0] duration_ms;
		logic [LED_W-1:0]  led_number;
		logic              accepted;
		kind_t             command_kind;
	} result_t;

	// "set-led "
	function automatic logic [7:0] setled_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h73;
			3'd1: c = 8'h65;
			3'd2: c = 8'h74;
			3'd3: c = 8'h2d;
			3'd4: c = 8'h6c;
			3'd5: c = 8'h65;
			3'd6: c = 8'h64;
			3'd7: c = 8'h20;
			default: c = 8'h20;
		endcase
		return c;
	endfunction

	// "echo "
	function automatic logic [7:0] echo_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h65;
			3'd1: c = 8'h63;
			3'd2: c = 8'h68;
			3'd3: c = 8'h6f;
			3'd4: c = 8'h20;
			default: c = 8'h20;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### design/lclp_line.sv
// ----------------------------------------------------------------------------
// lclp_line: per-line parse state
// Holds position, prefix match flags and the LED and time fields of the
// current line; forms the line result from the beat being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lclp_line
	import lclp_pkg::*;
#(
	parameter int LINE_MAX   = MAX_LINE,
	parameter int DIGITS_MAX = MAX_DIGITS
)
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              beat,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              line_end,
	input  wire logic [LED_W-1:0]  led_count,
	input  wire logic [TIME_W-1:0] time_limit,
	output result_t                res
);

	logic [POS_W-1:0]  pos_q;
	logic              sm_q, em_q, cr_q, fe_q;
	logic [LED_W-1:0]  led_q;
	logic [TIME_W-1:0] acc_q;
	logic [CNT_W-1:0]  dc_q;

	logic [POS_W-1:0]  len;
	logic              sm_n, em_n, cr_n, fe_n;
	logic [LED_W-1:0]  led_n;
	logic [TIME_W-1:0] acc_n;
	logic [CNT_W-1:0]  dc_n;
	logic [LED_W-1:0]  top;
	logic [ACCX_W-1:0] acc_x10;
	logic              is_digit;
	logic              ok;
	kind_t             kind;

	assign top      = (led_count > LED_TOP_MAX) ? LED_TOP_MAX : led_count;
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign acc_x10  = ({{(ACCX_W-TIME_W){1'b0}}, acc_q} << 3)
	                + ({{(ACCX_W-TIME_W){1'b0}}, acc_q} << 1)
	                + {{(ACCX_W-8){1'b0}}, rx_byte - CH_ZERO};

	always_comb begin
		sm_n  = sm_q;
		em_n  = em_q;
		cr_n  = cr_q;
		fe_n  = fe_q;
		led_n = led_q;
		acc_n = acc_q;
		dc_n  = dc_q;

		if (pos_q >= POS_W'(LINE_MAX))
			fe_n = 1'b1;
		if (pos_q < POS_W'(SETLED_LEN) && rx_byte != setled_char(pos_q[2:0]))
			sm_n = 1'b0;
		if (pos_q < POS_W'(ECHO_LEN) && rx_byte != echo_char(pos_q[2:0]))
			em_n = 1'b0;

		if (pos_q == POS_W'(POS_LED)) begin
			if (rx_byte >= CH_ONE && rx_byte <= CH_ZERO + {4'd0, top})
				led_n = LED_W'(rx_byte - CH_ZERO);
			else
				fe_n = 1'b1;
		end else if (pos_q == POS_W'(POS_COMMA)) begin
			if (rx_byte != CH_COMMA)
				fe_n = 1'b1;
		end else if (pos_q >= POS_W'(POS_DIGITS) && !cr_q) begin
			priority if (rx_byte == CH_CR) begin
				cr_n = 1'b1;
				if (dc_q == '0)
					fe_n = 1'b1;
			end else if (is_digit) begin
				if (dc_q >= CNT_W'(DIGITS_MAX)) begin
					fe_n = 1'b1;
				end else begin
					// saturate so an overlong value can never pass the limit
					acc_n = (acc_x10 > {{(ACCX_W-TIME_W){1'b0}}, ACC_MAX})
					      ? ACC_MAX : acc_x10[TIME_W-1:0];
					dc_n  = dc_q + CNT_W'(1);
				end
			end else begin
				fe_n = 1'b1;
			end
		end
	end

	assign len = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : POS_MAX;

	always_comb begin
		priority if (sm_n && len >= POS_W'(SETLED_LEN))
			kind = KIND_SETLED;
		else if (em_n && len >= POS_W'(ECHO_LEN))
			kind = KIND_ECHO;
		else
			kind = KIND_NONE;
	end

	assign ok = (kind == KIND_SETLED) && !fe_n && cr_n && (acc_n != '0)
	         && (acc_n < time_limit);

	always_comb begin
		res.command_kind = kind;
		res.accepted     = ok;
		res.led_number   = ok ? led_n : '0;
		res.duration_ms  = ok ? acc_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sm_q  <= 1'b1;
			em_q  <= 1'b1;
			cr_q  <= 1'b0;
			fe_q  <= 1'b0;
			led_q <= '0;
			acc_q <= '0;
			dc_q  <= '0;
		end else if (beat) begin
			if (line_end) begin
				// start the next line from scratch
				pos_q <= '0;
				sm_q  <= 1'b1;
				em_q  <= 1'b1;
				cr_q  <= 1'b0;
				fe_q  <= 1'b0;
				led_q <= '0;
				acc_q <= '0;
				dc_q  <= '0;
			end else begin
				pos_q <= len;
				sm_q  <= sm_n;
				em_q  <= em_n;
				cr_q  <= cr_n;
				fe_q  <= fe_n;
				led_q <= led_n;
				acc_q <= acc_n;
				dc_q  <= dc_n;
			end
		end
	end

endmodule

`default_nettype wire

### design/led_command_line_parser.sv
// ----------------------------------------------------------------------------
// led_command_line_parser: LED command-line parser
// Parses one received byte per beat and reports the command on the last
// byte of each line.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | contents
//  s_       | in  | s_tvalid / s_tready  | tdata: rx_byte; tlast: line_end
//  m_       | out | m_tvalid / m_tready  | tdata: kind, accepted, led, time
//  cfg_     | in  | cfg_we               | cfg_index selects led_count/time_limit
//
// One beat per cycle; the result of a line is in the output register the
// cycle after its last byte is taken.
// Bytes that are not the line end are taken even while a result waits;
// a line-end byte waits only while the output register is full and stalled.
// Reset restores led_count 4, time_limit 5000 and an empty line.
// ----------------------------------------------------------------------------
`default_nettype none

module led_command_line_parser
	import lclp_pkg::*;
#(
	parameter int LINE_MAX   = MAX_LINE,
	parameter int DIGITS_MAX = MAX_DIGITS
)
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [7:0]       s_tdata,   // [7:0] rx_byte
	input  wire logic             s_tlast,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// [1:0] command_kind, [2] accepted, [6:3] led_number, [20:7] duration_ms
	output logic [23:0]           m_tdata,
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic [LED_W-1:0]  led_count_q;
	logic [TIME_W-1:0] time_limit_q;
	logic              out_valid_q;
	result_t           out_q;
	result_t           res;
	logic              beat;

	assign s_tready = !out_valid_q || m_tready || !s_tlast;
	assign beat     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q  <= DEF_LED_COUNT;
			time_limit_q <= DEF_TIME_LIMIT;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_LED_COUNT:  led_count_q  <= cfg_data[LED_W-1:0];
				REG_TIME_LIMIT: time_limit_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	lclp_line #(
		.LINE_MAX   (LINE_MAX),
		.DIGITS_MAX (DIGITS_MAX)
	) u_line (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (beat),
		.rx_byte    (s_tdata),
		.line_end   (s_tlast),
		.led_count  (led_count_q),
		.time_limit (time_limit_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (beat && s_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat && s_tlast)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.duration_ms, out_q.led_number, out_q.accepted,
	                   out_q.command_kind};

	a_accept_setled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == KIND_SETLED)
		else $error("accepted line without set-led prefix");

	a_accept_led: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[6:3] != '0 && m_tdata[6:3] <= LED_TOP_MAX)
		else $error("accepted LED number out of range");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[20:3] == '0)
		else $error("rejected line carries LED or time");

	a_line_result: assert property (@(posedge clk) disable iff (!arst_n)
		beat && s_tlast |=> m_tvalid)
		else $error("line end gave no result");

endmodule

`default_nettype wire

### tb/lclp_tb_pkg.sv
// ----------------------------------------------------------------------------
// lclp_tb_pkg: result prediction and checking for the command-line parser
// Tracks one command line byte by byte, predicts the report sent on the
// line-end byte and compares reports from the block against it in order.
// ----------------------------------------------------------------------------
package lclp_tb_pkg;
	import lclp_pkg::*;

	class led_command_scoreboard;
		logic [LED_W-1:0]  led_count;
		logic [TIME_W-1:0] time_limit;
		int unsigned       pos;
		bit                is_setled;
		bit                is_echo;
		bit                cr_seen;
		bit                bad_format;
		int unsigned       led_digit;
		int unsigned       total_ms;
		int unsigned       n_digits;
		result_t           expected_reports[$];
		int                errors;

		function new();
			led_count  = DEF_LED_COUNT;
			time_limit = DEF_TIME_LIMIT;
			errors     = 0;
			start_line();
		endfunction

		function void start_line();
			pos        = 0;
			is_setled  = 1'b1;
			is_echo    = 1'b1;
			cr_seen    = 1'b0;
			bad_format = 1'b0;
			led_digit  = 0;
			total_ms   = 0;
			n_digits   = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_LED_COUNT:  led_count  = value[LED_W-1:0];
				REG_TIME_LIMIT: time_limit = value[TIME_W-1:0];
				default: ;
			endcase
		endfunction

		function void fail(string what);
			errors++;
			if (errors <= 10)
				$display("[%0t] %s", $time, what);
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			string       setled_text = "set-led ";
			string       echo_text   = "echo ";
			int unsigned top;
			int unsigned len;
			kind_t       kind;
			bit          ok;
			result_t     r;

			if (pos >= MAX_LINE)
				bad_format = 1'b1;
			if (pos < SETLED_LEN && b != setled_text[pos])
				is_setled = 1'b0;
			if (pos < ECHO_LEN && b != echo_text[pos])
				is_echo = 1'b0;

			if (pos == POS_LED) begin
				// counts above nine act as nine
				top = (led_count > LED_TOP_MAX) ? LED_TOP_MAX : led_count;
				if (b >= CH_ONE && b <= CH_ZERO + top)
					led_digit = b - CH_ZERO;
				else
					bad_format = 1'b1;
			end else if (pos == POS_COMMA) begin
				if (b != CH_COMMA)
					bad_format = 1'b1;
			end else if (pos >= POS_DIGITS && !cr_seen) begin
				if (b == CH_CR) begin
					cr_seen = 1'b1;
					if (n_digits == 0)
						bad_format = 1'b1;
				end else if (b >= CH_ZERO && b <= CH_NINE) begin
					if (n_digits >= MAX_DIGITS) begin
						bad_format = 1'b1;
					end else begin
						total_ms = total_ms * 10 + (b - CH_ZERO);
						if (total_ms > ACC_MAX)
							total_ms = ACC_MAX;
						n_digits++;
					end
				end else begin
					bad_format = 1'b1;
				end
			end

			len = (pos < POS_MAX) ? pos + 1 : POS_MAX;
			pos = len;
			if (!last)
				return;

			kind = KIND_NONE;
			if (is_setled && len >= SETLED_LEN)
				kind = KIND_SETLED;
			else if (is_echo && len >= ECHO_LEN)
				kind = KIND_ECHO;
			ok = kind == KIND_SETLED && !bad_format && cr_seen &&
				total_ms >= 1 && total_ms < time_limit;

			r.command_kind = kind;
			r.accepted     = ok;
			r.led_number   = ok ? LED_W'(led_digit) : '0;
			r.duration_ms  = ok ? TIME_W'(total_ms) : '0;
			expected_reports.push_back(r);
			start_line();
		endfunction

		function void check_result(result_t got);
			result_t want;

			if (expected_reports.size() == 0) begin
				fail($sformatf("unexpected report: kind %0d acc %0d led %0d ms %0d",
					got.command_kind, got.accepted, got.led_number, got.duration_ms));
				return;
			end
			want = expected_reports.pop_front();
			if (got.command_kind !== want.command_kind || got.accepted !== want.accepted ||
				got.led_number !== want.led_number || got.duration_ms !== want.duration_ms)
				fail($sformatf({"report mismatch: expected kind %0d acc %0d led %0d ms %0d,",
					" got kind %0d acc %0d led %0d ms %0d"},
					want.command_kind, want.accepted, want.led_number, want.duration_ms,
					got.command_kind, got.accepted, got.led_number, got.duration_ms));
		endfunction

		function void check_drained();
			if (expected_reports.size() != 0)
				fail($sformatf("%0d reports never arrived", expected_reports.size()));
			errors += (expected_reports.size() > 1) ? expected_reports.size() - 1 : 0;
		endfunction
	endclass

endpackage

### tb/led_command_line_parser_tb.sv
// ----------------------------------------------------------------------------
// led_command_line_parser_tb: stream test of the LED command-line parser
// Sends directed and random command lines under several register settings
// and idle patterns, predicts each line report and checks it in order.
// ----------------------------------------------------------------------------
module led_command_line_parser_tb;
	import lclp_pkg::*;
	import lclp_tb_pkg::*;

	localparam int RUN_LIMIT    = 2000000;
	localparam int PHASES       = 8;
	localparam int PHASE_BYTES  = 170;
	localparam int DRAIN_CYCLES = 4;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata   = '0;
	logic             s_tlast   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [23:0]      m_tdata;
	logic             cfg_we    = 1'b0;
	logic [0:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	logic [7:0]  line_q[$];

	led_command_scoreboard command_board = new();

	led_command_line_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			command_board.note_byte(s_tdata, s_tlast);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			command_board.check_result(result_t'(m_tdata[20:0]));
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_line();
		int i;
		for (i = 0; i < line_q.size(); i++)
			send_byte(line_q[i], i == line_q.size() - 1);
	endtask

	// hold the sender until every report is in and the block has settled
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		// let the monitor note the last beat before looking at the queue
		@(posedge clk);
		while (command_board.expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input int unsigned leds, input int unsigned limit);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LED_COUNT;
		cfg_data  <= CFG_W'(leds);
		@(posedge clk);
		command_board.write_reg(REG_LED_COUNT, CFG_W'(leds));
		cfg_index <= REG_TIME_LIMIT;
		cfg_data  <= CFG_W'(limit);
		@(posedge clk);
		command_board.write_reg(REG_TIME_LIMIT, CFG_W'(limit));
		cfg_we <= 1'b0;
	endtask

	task automatic put_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	task automatic put_number(input int unsigned value, input int unsigned ndig);
		int unsigned p;
		int unsigned i;
		p = 1;
		for (i = 1; i < ndig; i++)
			p *= 10;
		for (i = 0; i < ndig; i++) begin
			line_q.push_back(8'(CH_ZERO + (value / p) % 10));
			p /= 10;
		end
	endtask

	task automatic send_text(input string s);
		line_q.delete();
		put_text(s);
		send_line();
	endtask

	task automatic make_line();
		int unsigned pick;
		int unsigned top;
		int unsigned value;
		int unsigned ndig;
		int unsigned t;
		int unsigned n;
		int unsigned i;

		line_q.delete();
		pick = $urandom_range(99);
		if (pick < 65) begin
			put_text("set-led ");
			top = (command_board.led_count > LED_TOP_MAX) ? LED_TOP_MAX
			    : command_board.led_count;
			if (top >= 1 && $urandom_range(9) < 7)
				line_q.push_back(8'(CH_ZERO + $urandom_range(top, 1)));
			else if ($urandom_range(1))
				line_q.push_back(8'(CH_ZERO + $urandom_range(9)));
			else
				line_q.push_back(8'($urandom_range(255)));
			line_q.push_back(CH_COMMA);
			case ($urandom_range(4))
				0: value = command_board.time_limit - 1;
				1: value = command_board.time_limit;
				2: value = $urandom_range(9);
				default: value = $urandom_range(9999);
			endcase
			if (value > 9999)
				value = 9999;
			ndig = 1;
			for (t = value; t >= 10; t /= 10)
				ndig++;
			// leading zero now and then
			if (ndig < MAX_DIGITS && $urandom_range(3) == 0)
				ndig++;
			put_number(value, ndig);
			line_q.push_back(CH_CR);
			if ($urandom_range(3) == 0) begin
				n = $urandom_range(3, 1);
				for (i = 0; i < n; i++)
					line_q.push_back(8'($urandom_range(255)));
			end
			if ($urandom_range(99) < 30) begin
				case ($urandom_range(4))
					0: line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
					1: begin
						n = $urandom_range(line_q.size() - 1, 1);
						while (line_q.size() > n)
							line_q.delete(line_q.size() - 1);
					end
					2: line_q.insert(POS_DIGITS, 8'(CH_ZERO + $urandom_range(9)));
					3: line_q.insert($urandom_range(line_q.size() - 1), 8'($urandom_range(255)));
					default: begin
						n = $urandom_range(40, 16);
						while (line_q.size() < n)
							line_q.push_back(8'($urandom_range(255)));
					end
				endcase
			end
		end else if (pick < 80) begin
			put_text("echo ");
			n = $urandom_range(8);
			for (i = 0; i < n; i++)
				line_q.push_back(8'($urandom_range(126, 32)));
			if ($urandom_range(3) == 0)
				line_q.delete(line_q.size() - 1);
		end else if (pick < 93) begin
			n = $urandom_range(20, 1);
			for (i = 0; i < n; i++)
				line_q.push_back(8'($urandom_range(255)));
			if ($urandom_range(1))
				line_q[0] = $urandom_range(1) ? 8'h73 : 8'h65;
		end else begin
			n = $urandom_range(40, 16);
			put_text("set-led 1,1");
			line_q.push_back(CH_CR);
			while (line_q.size() < n)
				line_q.push_back(8'($urandom_range(255)));
		end
		if (line_q.size() == 0)
			line_q.push_back(8'($urandom_range(255)));
	endtask

	initial begin
		int phase;
		int sent;
		int i;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("set-led 1,1\015");
		send_text("set-led 4,4999\015");
		send_text("set-led 5,10\015");
		send_text("set-led 0,10\015");
		send_text("set-led 3,5000\015");
		send_text("set-led 3,0\015");
		send_text("set-led 2;10\015");
		send_text("set-led 2,\015");
		send_text("set-led 2,12345\015");
		send_text("set-led 2,12");
		send_text("set-l");
		send_text("echo hi");
		send_text("ech");
		send_text("set-led 1,9\015XYZ");
		send_text("set-led 1,9x\015");
		send_text("set-led 3,0042\015");
		// run past the position counter's saturation
		line_q.delete();
		put_text("set-led 1,9\015");
		for (i = 0; i < 28; i++)
			line_q.push_back(8'h7a);
		send_line();
		line_q.delete();
		line_q.push_back(8'h00);
		send_line();
		line_q.delete();
		line_q.push_back(8'hff);
		send_line();

		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: write_config(9, 10000);
				1: write_config(1, 2);
				2: write_config(15, 16383);
				3: write_config(0, 0);
				4: write_config(5, 1);
				5: write_config(4, 5000);
				6: write_config(2, 100);
				default: write_config($urandom_range(15), $urandom_range(16383));
			endcase
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 75;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 75;
				end
				default: begin
					send_idle_pct = 26;
					stall_pct     = 26;
				end
			endcase
			sent = 0;
			while (sent < PHASE_BYTES) begin
				make_line();
				send_line();
				sent += line_q.size();
			end
		end

		wait_idle();
		command_board.check_drained();
		if (command_board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
